[rtl/core/corner_stencil_relax_3d_defines.svh]
// Assertion macros shared by the corner stencil relaxation RTL.
`ifndef CORNER_STENCIL_RELAX_3D_DEFINES_SVH
`define CORNER_STENCIL_RELAX_3D_DEFINES_SVH
`ifndef ASSERT_OFF
`define CSR3D_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);
`define CSR3D_ASSERT_NEXT(lbl, clk_sig, rst_sig, pre, post, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (pre) |=> (post)) \
    else $error(msg);
`else
`define CSR3D_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define CSR3D_ASSERT_NEXT(lbl, clk_sig, rst_sig, pre, post, msg)
`endif
`endif

[rtl/core/csr3d_pkg.sv]
// Types, constants and helper functions of the corner stencil relaxation block.
package csr3d_pkg;

  localparam int MAX_X = 64;
  localparam int MAX_Y = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS = SAMPLE_BITS + 3;

  localparam int SIZE_BITS = 7;
  localparam int DEPTH_BITS = 16;
  localparam int AREA_BITS = 2 * SIZE_BITS;
  localparam int X_BITS = 6;
  localparam int Y_BITS = 6;
  localparam int Z_BITS = 16;

  localparam int LINE_DIST_BITS = $clog2(2 * MAX_X + 1);
  localparam int PLANE_DIST_BITS = $clog2(2 * MAX_X * MAX_Y + 2 * MAX_X + 1);

  localparam int PLANE_DEPTH = 2 * MAX_X * MAX_Y + 2 * MAX_X + 2;
  localparam int PLANE_AW = $clog2(PLANE_DEPTH);
  localparam int LINE_DEPTH = 2 * MAX_X + 2;
  localparam int LINE_AW = $clog2(LINE_DEPTH);

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;
  localparam int REG_IDX_BITS = ADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_WIDTH = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_DEPTH = 2'd2;

  localparam logic [SIZE_BITS-1:0] MIN_SIZE = 7'd3;
  localparam logic [DEPTH_BITS-1:0] MIN_DEPTH = 16'd3;
  localparam logic [SIZE_BITS-1:0] RESET_WIDTH = 7'd64;
  localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 7'd64;
  localparam logic [DEPTH_BITS-1:0] RESET_DEPTH = 16'd64;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SAMPLE_BITS:0] part_t;
  typedef logic signed [OUT_BITS-1:0] value_t;

  typedef struct packed {
    sample_t cur;
    sample_t back2;
  } pair_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]       width;
    logic [SIZE_BITS-1:0]       height;
    logic [DEPTH_BITS-1:0]      depth;
    logic [LINE_DIST_BITS-1:0]  dist_line;
    logic [PLANE_DIST_BITS-1:0] dist_plane;
    logic [PLANE_DIST_BITS-1:0] dist_corner;
  } cfg_t;

  typedef struct packed {
    logic              emit;
    logic [X_BITS-1:0] x;
    logic [Y_BITS-1:0] y;
    logic [Z_BITS-1:0] z;
    logic              last;
  } point_t;

  function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] raw,
                                                      input logic [SIZE_BITS-1:0] limit);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic cfg_t make_cfg(input logic [SIZE_BITS-1:0] w_raw,
                                    input logic [SIZE_BITS-1:0] h_raw,
                                    input logic [DEPTH_BITS-1:0] d_raw);
    cfg_t c;
    logic [AREA_BITS-1:0] area;
    c.width = clamp_size(w_raw, SIZE_BITS'(MAX_X));
    c.height = clamp_size(h_raw, SIZE_BITS'(MAX_Y));
    c.depth = (d_raw < MIN_DEPTH) ? MIN_DEPTH : d_raw;
    area = AREA_BITS'(c.width) * AREA_BITS'(c.height);
    c.dist_line = LINE_DIST_BITS'({c.width, 1'b0});
    c.dist_plane = PLANE_DIST_BITS'({area, 1'b0});
    c.dist_corner = c.dist_plane + PLANE_DIST_BITS'(c.dist_line);
    return c;
  endfunction

endpackage

[rtl/core/corner_stencil_relax_3d.sv]
// Top level of the streaming 3D eight-corner stencil relaxation block.
//
//   Channel  Ports                                   Direction  Beat
//   in       in_valid/in_ready, in_sample, in_frame_start   in   one grid sample
//   out      out_valid/out_ready, out_relaxed_value,        out  one interior point
//            out_point_x/y/z, out_last_point
//   cfg      psel, penable, pwrite, paddr, pwdata, prdata   in   one register write or read
//
// One sample is taken per cycle while in_ready is high; results pass s1, s2 and out.
// The plane memory serves its two corner reads and one write for each accepted sample.
// Reset is synchronous and active low; the delay memories are not cleared and need no sweep.
// A stall on the output backs up through two stages before in_ready drops.
// Boundary samples pass the pipeline without producing a beat.
module corner_stencil_relax_3d import csr3d_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                       in_frame_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] out_relaxed_value,
  output logic [X_BITS-1:0]          out_point_x,
  output logic [Y_BITS-1:0]          out_point_y,
  output logic [Z_BITS-1:0]          out_point_z,
  output logic                       out_last_point,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_BITS-1:0]       paddr,
  input  logic [DATA_BITS-1:0]       pwdata,
  output logic [DATA_BITS-1:0]       prdata,
  output logic                       pready
);

  cfg_t    cfg;
  point_t  point;
  sample_t back2;
  pair_t   line_tap, plane_tap, corner_tap;
  logic    accept;

  csr3d_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csr3d_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_start (in_frame_start),
    .sample      (in_sample),
    .cfg         (cfg),
    .point       (point),
    .back2       (back2)
  );

  csr3d_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sample     (in_sample),
    .back2      (back2),
    .cfg        (cfg),
    .line_tap   (line_tap),
    .plane_tap  (plane_tap),
    .corner_tap (corner_tap)
  );

  csr3d_sum u_sum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .accept     (accept),
    .point      (point),
    .sample     (in_sample),
    .back2      (back2),
    .line_tap   (line_tap),
    .plane_tap  (plane_tap),
    .corner_tap (corner_tap),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_relaxed_value),
    .out_x      (out_point_x),
    .out_y      (out_point_y),
    .out_z      (out_point_z),
    .out_last   (out_last_point)
  );

endmodule

[rtl/core/csr3d_cfg.sv]
// Configuration registers with the APB-style port and the derived tap distances.
module csr3d_cfg import csr3d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic [SIZE_BITS-1:0]    width_r, width_nxt;
  logic [SIZE_BITS-1:0]    height_r, height_nxt;
  logic [DEPTH_BITS-1:0]   depth_r, depth_nxt;
  cfg_t                    cfg_r;
  logic                    wr;
  logic [REG_IDX_BITS-1:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[ADDR_BITS-1:2];
  assign wr = psel && penable && pwrite;
  assign cfg = cfg_r;

  always_comb begin
    width_nxt = width_r;
    height_nxt = height_r;
    depth_nxt = depth_r;
    if (wr) begin
      case (idx)
        REG_WIDTH: width_nxt = pwdata[SIZE_BITS-1:0];
        REG_HEIGHT: height_nxt = pwdata[SIZE_BITS-1:0];
        REG_DEPTH: depth_nxt = pwdata[DEPTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH: prdata = DATA_BITS'(width_r);
      REG_HEIGHT: prdata = DATA_BITS'(height_r);
      REG_DEPTH: prdata = DATA_BITS'(depth_r);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      depth_r <= RESET_DEPTH;
      cfg_r <= make_cfg(RESET_WIDTH, RESET_HEIGHT, RESET_DEPTH);
    end else begin
      width_r <= width_nxt;
      height_r <= height_nxt;
      depth_r <= depth_nxt;
      cfg_r <= make_cfg(width_nxt, height_nxt, depth_nxt);
    end
  end

endmodule

[rtl/core/csr3d_pos.sv]
// Raster position tracking, interior test and short sample history.
`include "corner_stencil_relax_3d_defines.svh"
module csr3d_pos import csr3d_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    accept,
  input  logic    frame_start,
  input  sample_t sample,
  input  cfg_t    cfg,
  output point_t  point,
  output sample_t back2
);

  localparam int XB1 = X_BITS + 1;
  localparam int YB1 = Y_BITS + 1;
  localparam int ZB1 = Z_BITS + 1;

  logic [X_BITS-1:0] pos_x_r, pos_x_nxt, px;
  logic [Y_BITS-1:0] pos_y_r, pos_y_nxt, py;
  logic [Z_BITS-1:0] pos_z_r, pos_z_nxt, pz;
  logic [XB1-1:0]    x_inc;
  logic [YB1-1:0]    y_inc;
  logic [ZB1-1:0]    z_inc;
  sample_t           hist1_r, hist2_r;

  assign back2 = hist2_r;

  always_comb begin
    px = frame_start ? '0 : pos_x_r;
    py = frame_start ? '0 : pos_y_r;
    pz = frame_start ? '0 : pos_z_r;
    x_inc = {1'b0, px} + XB1'(1);
    y_inc = {1'b0, py} + YB1'(1);
    z_inc = {1'b0, pz} + ZB1'(1);

    point.emit = (px >= X_BITS'(2)) && (SIZE_BITS'({1'b0, px}) < cfg.width) &&
                 (py >= Y_BITS'(2)) && (SIZE_BITS'({1'b0, py}) < cfg.height) &&
                 (pz >= Z_BITS'(2)) && (pz < cfg.depth);
    point.x = px - X_BITS'(1);
    point.y = py - Y_BITS'(1);
    point.z = pz - Z_BITS'(1);
    point.last = (SIZE_BITS'({1'b0, px}) == cfg.width - SIZE_BITS'(1)) &&
                 (SIZE_BITS'({1'b0, py}) == cfg.height - SIZE_BITS'(1)) &&
                 (pz == cfg.depth - Z_BITS'(1));

    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (accept) begin
      pos_y_nxt = py;
      pos_z_nxt = pz;
      if (SIZE_BITS'(x_inc) >= cfg.width) begin
        pos_x_nxt = '0;
        if (SIZE_BITS'(y_inc) >= cfg.height) begin
          pos_y_nxt = '0;
          if (z_inc >= {1'b0, cfg.depth}) begin
            pos_z_nxt = '0;
          end else begin
            pos_z_nxt = z_inc[Z_BITS-1:0];
          end
        end else begin
          pos_y_nxt = y_inc[Y_BITS-1:0];
        end
      end else begin
        pos_x_nxt = x_inc[X_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist1_r <= sample;
      hist2_r <= hist1_r;
    end
  end

  `CSR3D_ASSERT_NEXT(a_frame_restart, clk, rst_n, accept && frame_start, pos_x_r == X_BITS'(1) && pos_y_r == '0 && pos_z_r == '0, "frame start did not restart the position")
  `CSR3D_ASSERT_NEXT(a_last_wraps, clk, rst_n, accept && point.emit && point.last, pos_x_r == '0 && pos_y_r == '0 && pos_z_r == '0, "position did not wrap after the last point")

endmodule

[rtl/core/csr3d_store.sv]
// Plane and line delay memories holding sample pairs, with registered tap reads.
`include "corner_stencil_relax_3d_defines.svh"
module csr3d_store import csr3d_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    accept,
  input  sample_t sample,
  input  sample_t back2,
  input  cfg_t    cfg,
  output pair_t   line_tap,
  output pair_t   plane_tap,
  output pair_t   corner_tap
);

  localparam int PAW1 = PLANE_AW + 1;
  localparam int LAW1 = LINE_AW + 1;

  pair_t plane_mem [PLANE_DEPTH];
  pair_t line_mem [LINE_DEPTH];

  logic [PLANE_AW-1:0] plane_wp_r, plane_wp_nxt;
  logic [LINE_AW-1:0]  line_wp_r, line_wp_nxt;
  logic [PAW1-1:0]     diff_a, diff_b;
  logic [LAW1-1:0]     diff_l;
  logic [PLANE_AW-1:0] plane_raddr_a, plane_raddr_b;
  logic [LINE_AW-1:0]  line_raddr;
  pair_t               wr_pair;
  pair_t               line_rd_r, plane_rd_a_r, plane_rd_b_r;

  assign line_tap = line_rd_r;
  assign plane_tap = plane_rd_a_r;
  assign corner_tap = plane_rd_b_r;

  always_comb begin
    wr_pair.cur = sample;
    wr_pair.back2 = back2;

    diff_a = {1'b0, plane_wp_r} - PAW1'(cfg.dist_plane);
    diff_b = {1'b0, plane_wp_r} - PAW1'(cfg.dist_corner);
    diff_l = {1'b0, line_wp_r} - LAW1'(cfg.dist_line);
    plane_raddr_a = diff_a[PLANE_AW] ? PLANE_AW'(diff_a + PAW1'(PLANE_DEPTH))
                                     : diff_a[PLANE_AW-1:0];
    plane_raddr_b = diff_b[PLANE_AW] ? PLANE_AW'(diff_b + PAW1'(PLANE_DEPTH))
                                     : diff_b[PLANE_AW-1:0];
    line_raddr = diff_l[LINE_AW] ? LINE_AW'(diff_l + LAW1'(LINE_DEPTH))
                                 : diff_l[LINE_AW-1:0];

    plane_wp_nxt = plane_wp_r;
    line_wp_nxt = line_wp_r;
    if (accept) begin
      plane_wp_nxt = (plane_wp_r == PLANE_AW'(PLANE_DEPTH - 1)) ? '0
                                                                : plane_wp_r + PLANE_AW'(1);
      line_wp_nxt = (line_wp_r == LINE_AW'(LINE_DEPTH - 1)) ? '0
                                                            : line_wp_r + LINE_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_wp_r <= '0;
      line_wp_r <= '0;
    end else begin
      plane_wp_r <= plane_wp_nxt;
      line_wp_r <= line_wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plane_mem[plane_wp_r] <= wr_pair;
      plane_rd_a_r <= plane_mem[plane_raddr_a];
      plane_rd_b_r <= plane_mem[plane_raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[line_wp_r] <= wr_pair;
      line_rd_r <= line_mem[line_raddr];
    end
  end

  `CSR3D_ASSERT(a_plane_no_collide, clk, rst_n, accept |-> plane_raddr_a != plane_wp_r && plane_raddr_b != plane_wp_r, "plane read address meets the write address")
  `CSR3D_ASSERT(a_line_no_collide, clk, rst_n, accept |-> line_raddr != line_wp_r, "line read address meets the write address")
  `CSR3D_ASSERT_NEXT(a_wp_step, clk, rst_n, accept && plane_wp_r != PLANE_AW'(PLANE_DEPTH - 1), plane_wp_r == $past(plane_wp_r) + PLANE_AW'(1), "plane write pointer skipped")

endmodule

[rtl/core/csr3d_sum.sv]
// Three-stage adder pipeline with the input handshake and the result register.
`include "corner_stencil_relax_3d_defines.svh"
module csr3d_sum import csr3d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              accept,
  input  point_t            point,
  input  sample_t           sample,
  input  sample_t           back2,
  input  pair_t             line_tap,
  input  pair_t             plane_tap,
  input  pair_t             corner_tap,
  output logic              out_valid,
  input  logic              out_ready,
  output value_t            out_value,
  output logic [X_BITS-1:0] out_x,
  output logic [Y_BITS-1:0] out_y,
  output logic [Z_BITS-1:0] out_z,
  output logic              out_last
);

  logic    s1_valid_r, s1_valid_nxt;
  point_t  s1_point_r;
  sample_t s1_cur_r, s1_back2_r;
  logic    s1_adv;

  logic    s2_valid_r, s2_valid_nxt;
  point_t  s2_point_r;
  part_t   s2_part_r [4];
  part_t   part_nxt [4];
  logic    s2_adv, s2_free;

  logic    out_valid_r, out_valid_nxt;
  value_t  out_value_r, value_nxt;
  point_t  out_point_r;

  always_comb begin
    s2_adv = s2_valid_r && (!out_valid_r || out_ready);
    s2_free = !s2_valid_r || s2_adv;
    s1_adv = s1_valid_r && (!s1_point_r.emit || s2_free);
    in_ready = !s1_valid_r || s1_adv;
    accept = in_valid && in_ready;

    s1_valid_nxt = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    s2_valid_nxt = (s1_adv && s1_point_r.emit) ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_r);
    out_valid_nxt = s2_adv ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);

    part_nxt[0] = part_t'(s1_cur_r) + part_t'(s1_back2_r);
    part_nxt[1] = part_t'(line_tap.cur) + part_t'(line_tap.back2);
    part_nxt[2] = part_t'(plane_tap.cur) + part_t'(plane_tap.back2);
    part_nxt[3] = part_t'(corner_tap.cur) + part_t'(corner_tap.back2);

    value_nxt = value_t'(s2_part_r[0]) + value_t'(s2_part_r[1]) +
                value_t'(s2_part_r[2]) + value_t'(s2_part_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_point_r <= point;
      s1_cur_r <= sample;
      s1_back2_r <= back2;
    end
    if (s1_adv && s1_point_r.emit) begin
      s2_point_r <= s1_point_r;
      s2_part_r <= part_nxt;
    end
    if (s2_adv) begin
      out_point_r <= s2_point_r;
      out_value_r <= value_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_x = out_point_r.x;
  assign out_y = out_point_r.y;
  assign out_z = out_point_r.z;
  assign out_last = out_point_r.last;

  `CSR3D_ASSERT_NEXT(a_emit_reaches_s2, clk, rst_n, s1_adv && s1_point_r.emit, s2_valid_r, "interior point lost between stages")
  `CSR3D_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_cur_r), "stalled first stage changed")
  `CSR3D_ASSERT(a_s2_only_emit, clk, rst_n, s2_valid_r |-> s2_point_r.emit, "boundary point entered the adder stage")

endmodule
